@@ hdl/sst_pkg.sv @@
`default_nettype none

package sst_pkg;

  localparam int NUM_TYPES    = 4;
  localparam int CAPACITY     = 32;
  localparam int MAX_ENTITIES = 1024;
  localparam int DATA_WIDTH   = 32;

  localparam int FUNC_W      = 3;
  localparam int ENT_W       = 10;
  localparam int TID_W       = 2;
  localparam int STATUS_W    = 2;
  localparam int TREG_W      = 3;
  localparam int TYPE_W      = $clog2(NUM_TYPES);
  localparam int TCNT_W      = $clog2(NUM_TYPES + 1);
  localparam int SLOT_W      = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int ENT_IDX_W   = $clog2(MAX_ENTITIES);
  localparam int MAP_AW      = TYPE_W + ENT_IDX_W;
  localparam int MAP_DEPTH   = NUM_TYPES * (2 ** ENT_IDX_W);
  localparam int DENSE_AW    = TYPE_W + SLOT_W;
  localparam int DENSE_DEPTH = NUM_TYPES * (2 ** SLOT_W);

  localparam logic [FUNC_W-1:0] FN_ADD     = 3'd0;
  localparam logic [FUNC_W-1:0] FN_REMOVE  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_GET     = 3'd2;
  localparam logic [FUNC_W-1:0] FN_WRITE   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_DESTROY = 3'd4;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK,
    STAT_INVALID,
    STAT_NOTFOUND,
    STAT_FULL
  } sst_status_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_TYPE_CHK,
    ST_LOOKUP,
    ST_DECIDE,
    ST_WR,
    ST_RD_A,
    ST_RD_B,
    ST_RM_A,
    ST_RM_B,
    ST_RM_C,
    ST_UNMAP,
    ST_NEXT_TYPE
  } sst_state_t;

  typedef struct packed {
    logic [FUNC_W-1:0]     func;
    logic [ENT_W-1:0]      entity;
    logic [TID_W-1:0]      type_id;
    logic [DATA_WIDTH-1:0] wdata;
  } sst_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [SLOT_W-1:0]     slot;
    logic [DATA_WIDTH-1:0] rdata;
    logic                  was_present;
  } sst_out_t;

  typedef struct packed {
    logic        load;
    logic        clear_step;
    logic        first_type;
    logic        next_type;
    logic        latch_hit;
    logic        rd_last;
    logic        cap_rdata;
    logic        cap_moved;
    logic        set_present;
    logic        set_slot;
    logic        set_status;
    sst_status_t status_code;
    logic        wr_data;
    logic        append;
    logic        mv;
    logic        unmap;
    logic        finish;
  } sst_cmd_t;

  typedef struct packed {
    logic              clear_last;
    logic [FUNC_W-1:0] func;
    logic              ent_bad;
    logic              type_ok;
    logic              more_types;
    logic              hit;
    logic              full;
    logic              same_slot;
  } sst_stat_t;

endpackage

`default_nettype wire

@@ hdl/sst_controller.sv @@
`default_nettype none

module sst_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  sst_pkg::sst_stat_t stat,
  output sst_pkg::sst_cmd_t  cmd
);
  import sst_pkg::*;

  sst_state_t state;
  sst_state_t state_next;
  logic       is_destroy;

  assign is_destroy = (stat.func == FN_DESTROY);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (stat.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (stat.func > FN_DESTROY || stat.ent_bad) begin
          state_next = ST_IDLE;
        end else if (is_destroy) begin
          state_next = ST_TYPE_CHK;
        end else if (!stat.type_ok) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_LOOKUP;
        end
      end
      ST_TYPE_CHK: begin
        state_next = stat.more_types ? ST_DECIDE : ST_IDLE;
      end
      ST_LOOKUP: state_next = ST_DECIDE;
      ST_DECIDE: begin
        if (is_destroy) begin
          state_next = stat.hit ? ST_RM_A : ST_NEXT_TYPE;
        end else if (stat.hit) begin
          case (stat.func)
            FN_REMOVE: state_next = ST_RM_A;
            FN_WRITE:  state_next = ST_WR;
            default:   state_next = ST_RD_A;
          endcase
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_WR:   state_next = ST_IDLE;
      ST_RD_A: state_next = ST_RD_B;
      ST_RD_B: state_next = ST_IDLE;
      ST_RM_A: state_next = ST_RM_B;
      ST_RM_B: state_next = ST_RM_C;
      ST_RM_C: state_next = ST_UNMAP;
      ST_UNMAP: begin
        state_next = is_destroy ? ST_NEXT_TYPE : ST_IDLE;
      end
      ST_NEXT_TYPE: state_next = ST_TYPE_CHK;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = (state != ST_IDLE);
    case (state)
      ST_CLEAR: cmd.clear_step = 1'b1;
      ST_IDLE:  cmd.load = start;
      ST_CHECK: begin
        if (stat.func > FN_DESTROY) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = STAT_NOTFOUND;
          cmd.finish      = 1'b1;
        end else if (stat.ent_bad) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = STAT_INVALID;
          cmd.finish      = 1'b1;
        end else if (!is_destroy && !stat.type_ok) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = STAT_NOTFOUND;
          cmd.finish      = 1'b1;
        end else begin
          cmd.first_type = 1'b1;
        end
      end
      ST_TYPE_CHK: cmd.finish = !stat.more_types;
      ST_LOOKUP: ;
      ST_DECIDE: begin
        cmd.latch_hit = 1'b1;
        if (!is_destroy && !stat.hit) begin
          cmd.finish = 1'b1;
          if (stat.func != FN_ADD) begin
            cmd.set_status  = 1'b1;
            cmd.status_code = STAT_NOTFOUND;
          end else if (stat.full) begin
            cmd.set_status  = 1'b1;
            cmd.status_code = STAT_FULL;
          end else begin
            cmd.append = 1'b1;
          end
        end
      end
      ST_WR: begin
        cmd.wr_data     = 1'b1;
        cmd.set_present = 1'b1;
        cmd.set_slot    = 1'b1;
        cmd.finish      = 1'b1;
      end
      ST_RD_A: ;
      ST_RD_B: begin
        cmd.cap_rdata   = 1'b1;
        cmd.set_present = 1'b1;
        cmd.set_slot    = 1'b1;
        cmd.finish      = 1'b1;
      end
      ST_RM_A: ;
      ST_RM_B: begin
        // The word at the hole comes back now, and the last slot's data word is addressed for the move.
        cmd.rd_last     = 1'b1;
        cmd.cap_moved   = 1'b1;
        cmd.set_present = 1'b1;
        cmd.cap_rdata   = !is_destroy;
        cmd.set_slot    = !is_destroy;
      end
      ST_RM_C: cmd.mv = !stat.same_slot;
      ST_UNMAP: begin
        cmd.unmap  = 1'b1;
        cmd.finish = !is_destroy;
      end
      ST_NEXT_TYPE: cmd.next_type = 1'b1;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/sst_datapath.sv @@
`default_nettype none

module sst_datapath (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [sst_pkg::TREG_W-1:0] cfg_data,
  input  sst_pkg::sst_in_t           item,
  input  sst_pkg::sst_cmd_t          cmd,
  output sst_pkg::sst_stat_t         stat,
  output sst_pkg::sst_out_t          result,
  output logic                       result_valid
);
  import sst_pkg::*;

  sst_in_t            item_q;
  sst_out_t           res;
  logic [TREG_W-1:0]  types_reg;
  logic [TCNT_W-1:0]  cur_type;
  logic [SLOT_W-1:0]  s_reg;
  logic [ENT_W-1:0]   moved;
  logic [MAP_AW-1:0]  clr_addr;
  logic [CNT_W-1:0]   count [NUM_TYPES];

  logic [CNT_W-1:0]      map_mem  [MAP_DEPTH];
  logic [ENT_W-1:0]      ent_mem  [DENSE_DEPTH];
  logic [DATA_WIDTH-1:0] data_mem [DENSE_DEPTH];
  logic [CNT_W-1:0]      map_q;
  logic [ENT_W-1:0]      ent_q;
  logic [DATA_WIDTH-1:0] data_q;

  logic [TYPE_W-1:0]     t_idx;
  logic [CNT_W-1:0]      cnt_cur;
  logic [SLOT_W-1:0]     last_slot;
  logic [MAP_AW-1:0]     map_raddr;
  logic                  map_we;
  logic [MAP_AW-1:0]     map_waddr;
  logic [CNT_W-1:0]      map_wdata;
  logic [DENSE_AW-1:0]   dense_raddr;
  logic [DENSE_AW-1:0]   dense_waddr;
  logic                  data_we;
  logic [DATA_WIDTH-1:0] data_wdata;
  logic                  ent_we;
  logic [ENT_W-1:0]      ent_wdata;

  assign t_idx     = cur_type[TYPE_W-1:0];
  assign cnt_cur   = count[t_idx];
  assign last_slot = SLOT_W'(cnt_cur - CNT_W'(1));
  assign map_raddr = {t_idx, item_q.entity[ENT_IDX_W-1:0]};
  assign dense_raddr = {t_idx, (cmd.rd_last ? last_slot : s_reg)};

  always_comb begin
    map_we    = 1'b0;
    map_waddr = map_raddr;
    map_wdata = '0;
    if (cmd.clear_step) begin
      map_we    = 1'b1;
      map_waddr = clr_addr;
    end else if (cmd.append) begin
      map_we    = 1'b1;
      map_wdata = CNT_W'(cnt_cur + CNT_W'(1));
    end else if (cmd.mv) begin
      // The entry moved out of the last slot now points at the hole.
      map_we    = 1'b1;
      map_waddr = {t_idx, moved[ENT_IDX_W-1:0]};
      map_wdata = CNT_W'(s_reg) + CNT_W'(1);
    end else if (cmd.unmap) begin
      map_we    = 1'b1;
    end
  end

  always_comb begin
    dense_waddr = {t_idx, s_reg};
    data_we     = 1'b0;
    data_wdata  = item_q.wdata;
    ent_we      = 1'b0;
    ent_wdata   = moved;
    if (cmd.append) begin
      dense_waddr = {t_idx, cnt_cur[SLOT_W-1:0]};
      data_we     = 1'b1;
      data_wdata  = '0;
      ent_we      = 1'b1;
      ent_wdata   = item_q.entity;
    end else if (cmd.mv) begin
      data_we     = 1'b1;
      data_wdata  = data_q;
      ent_we      = 1'b1;
    end else if (cmd.wr_data) begin
      data_we     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_waddr] <= map_wdata;
    map_q <= map_mem[map_raddr];
  end

  always_ff @(posedge clk) begin
    if (ent_we) ent_mem[dense_waddr] <= ent_wdata;
    ent_q <= ent_mem[{t_idx, last_slot}];
  end

  always_ff @(posedge clk) begin
    if (data_we) data_mem[dense_waddr] <= data_wdata;
    data_q <= data_mem[dense_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      types_reg    <= '0;
      clr_addr     <= '0;
      result_valid <= 1'b0;
      for (int i = 0; i < NUM_TYPES; i++) begin
        count[i] <= '0;
      end
    end else begin
      if (cfg_we) types_reg <= cfg_data;
      if (cmd.clear_step) clr_addr <= clr_addr + MAP_AW'(1);
      result_valid <= cmd.finish;
      if (cmd.append) begin
        count[t_idx] <= CNT_W'(cnt_cur + CNT_W'(1));
      end else if (cmd.unmap) begin
        count[t_idx] <= CNT_W'(cnt_cur - CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_q <= item;
      res    <= '0;
    end else begin
      if (cmd.set_status) res.status <= cmd.status_code;
      if (cmd.set_present) res.was_present <= 1'b1;
      if (cmd.set_slot) res.slot <= s_reg;
      if (cmd.append) res.slot <= cnt_cur[SLOT_W-1:0];
      if (cmd.cap_rdata) res.rdata <= data_q;
      if (cmd.wr_data) res.rdata <= item_q.wdata;
    end
    if (cmd.first_type) begin
      cur_type <= (item_q.func == FN_DESTROY) ? '0 : TCNT_W'(item_q.type_id);
    end else if (cmd.next_type) begin
      cur_type <= cur_type + TCNT_W'(1);
    end
    if (cmd.latch_hit) s_reg <= SLOT_W'(map_q - CNT_W'(1));
    if (cmd.cap_moved) moved <= ent_q;
  end

  always_comb begin
    stat.clear_last = (clr_addr == MAP_AW'(MAP_DEPTH - 1));
    stat.func       = item_q.func;
    stat.ent_bad    = (item_q.entity == '0) || (32'(item_q.entity) >= MAX_ENTITIES);
    stat.type_ok    = (32'(item_q.type_id) < 32'(types_reg)) &&
                      (32'(item_q.type_id) < NUM_TYPES);
    stat.more_types = (32'(cur_type) < 32'(types_reg)) && (32'(cur_type) < NUM_TYPES);
    // A map entry at or past the live count is stale and counts as absent.
    stat.hit        = (map_q != '0) && (CNT_W'(map_q - CNT_W'(1)) < cnt_cur);
    stat.full       = (32'(cnt_cur) >= CAPACITY);
    stat.same_slot  = (s_reg == last_slot);
  end

  assign result = res;

endmodule

`default_nettype wire

@@ hdl/sparse_set_component_table.sv @@
`default_nettype none

// Sparse-set component table: per component type, a packed list of entity ids
// with one data word each, and a map from entity id to slot plus one.
// Commands: start with the item word on item, accepted when busy is low.
// Each result word appears on result, marked by result_valid for exactly one
// cycle; the receiver cannot stall it, and the next command may be
// accepted in that same cycle.
// The configuration register (number of registered types) is written through
// cfg_we and cfg_data; the user must write it only while the block is idle,
// the block itself does not enforce this. Commands step through the controller
// states; rejected commands finish after the checks, and the others take their
// steps from the registered memory reads: a map lookup, then dependent
// dense-memory reads, and up to two map writes for a swap-remove. Destroy walks
// every registered type in turn and removes the entity from each that holds it.
// After reset the block clears all 4096 map entries, one entry a cycle; busy
// stays high during that pass and configuration writes are still taken. Reset
// also empties every type and clears the register.
module sparse_set_component_table (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  sst_pkg::sst_in_t           item,
  output sst_pkg::sst_out_t          result,
  output logic                       result_valid,
  input  logic                       cfg_we,
  input  logic [sst_pkg::TREG_W-1:0] cfg_data
);
  import sst_pkg::*;

  sst_cmd_t  cmd;
  sst_stat_t stat;

  sst_controller u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  sst_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .item         (item),
    .cmd          (cmd),
    .stat         (stat),
    .result       (result),
    .result_valid (result_valid)
  );

endmodule

`default_nettype wire

@@ tb/sv/sparse_set_component_table_tb.sv @@
`default_nettype none

module sparse_set_component_table_tb;
  import sst_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int FN_MAX     = (1 << FUNC_W) - 1;
  localparam int MAX_REPORTS = 10;

  typedef enum logic [1:0] {
    K_OP,
    K_CFG,
    K_DRAIN
  } step_kind_t;

  typedef struct {
    step_kind_t          kind;
    sst_in_t             word;
    logic [TREG_W-1:0]   treg;
  } step_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  sst_in_t           item = '0;
  sst_out_t          result;
  logic              result_valid;
  logic              cfg_we = 1'b0;
  logic [TREG_W-1:0] cfg_data = '0;

  // Mirror of the table contents.
  logic [CNT_W-1:0]      map_m  [NUM_TYPES][MAX_ENTITIES];
  logic [ENT_W-1:0]      ents_m [NUM_TYPES][CAPACITY];
  logic [DATA_WIDTH-1:0] data_m [NUM_TYPES][CAPACITY];
  int unsigned           live_m [NUM_TYPES];
  int unsigned           treg_m;

  step_t    op_q[$];
  sst_out_t outcome_q[$];
  int       bad_words = 0;
  int       hold_cnt = 0;
  int       burst_left = 0;
  int       idle_cycles = 0;
  logic     go;
  logic     we;
  step_t    head;
  sst_out_t exp_w;

  sparse_set_component_table uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result       (result),
    .result_valid (result_valid),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic int slot_of(int unsigned t, int unsigned e);
    int unsigned v;
    v = 32'(map_m[t][e]);
    if (v == 0 || v - 1 >= live_m[t]) begin
      return -1;
    end
    return int'(v - 1);
  endfunction

  // Swap-remove: the last entry moves into the hole.
  function automatic void drop_slot(int unsigned t, int unsigned e, int unsigned s);
    int unsigned      last;
    logic [ENT_W-1:0] moved;
    last = live_m[t] - 1;
    if (s != last) begin
      moved = ents_m[t][last];
      ents_m[t][s] = moved;
      data_m[t][s] = data_m[t][last];
      map_m[t][moved] = CNT_W'(s + 1);
    end
    live_m[t] = last;
    map_m[t][e] = '0;
  endfunction

  function automatic sst_out_t run_table_op(sst_in_t w);
    sst_out_t    r;
    int unsigned t;
    int unsigned e;
    int          s;
    r = '0;
    t = 32'(w.type_id);
    e = 32'(w.entity);
    if (w.func > FN_DESTROY) begin
      r.status = STAT_NOTFOUND;
    end else if (e == 0) begin
      r.status = STAT_INVALID;
    end else if (w.func == FN_DESTROY) begin
      for (int k = 0; k < NUM_TYPES && k < treg_m; k++) begin
        s = slot_of(k, e);
        if (s >= 0) begin
          drop_slot(k, e, s);
          r.was_present = 1'b1;
        end
      end
    end else if (t >= treg_m || t >= NUM_TYPES) begin
      r.status = STAT_NOTFOUND;
    end else begin
      s = slot_of(t, e);
      if (s >= 0) begin
        r.was_present = 1'b1;
        r.slot = SLOT_W'(s);
        if (w.func == FN_WRITE) begin
          data_m[t][s] = w.wdata;
        end
        r.rdata = data_m[t][s];
        if (w.func == FN_REMOVE) begin
          drop_slot(t, e, s);
        end
      end else if (w.func == FN_ADD) begin
        if (live_m[t] >= CAPACITY) begin
          r.status = STAT_FULL;
        end else begin
          ents_m[t][live_m[t]] = ENT_W'(e);
          data_m[t][live_m[t]] = '0;
          map_m[t][e] = CNT_W'(live_m[t] + 1);
          r.slot = SLOT_W'(live_m[t]);
          live_m[t] = live_m[t] + 1;
        end
      end else begin
        r.status = STAT_NOTFOUND;
      end
    end
    return r;
  endfunction

  task automatic queue_op(input logic [FUNC_W-1:0] f, input int e, input int t,
                          input logic [DATA_WIDTH-1:0] w);
    step_t st;
    st.kind = K_OP;
    st.treg = '0;
    st.word.func = f;
    st.word.entity = ENT_W'(e);
    st.word.type_id = TID_W'(t);
    st.word.wdata = w;
    op_q.push_back(st);
  endtask

  task automatic queue_cfg(input int treg);
    step_t st;
    st.kind = K_CFG;
    st.treg = TREG_W'(treg);
    st.word = '0;
    op_q.push_back(st);
  endtask

  // Random phase: entities mostly from a small pool so that adds, removes and
  // lookups keep hitting live entries and tables can fill up.
  task automatic queue_phase(input int treg, input int n, input int pool,
                             input int add_pct);
    logic [FUNC_W-1:0] f;
    int                e;
    int                t;
    int                roll;
    int                hi_type;
    step_t             st;
    queue_cfg(treg);
    hi_type = (treg > NUM_TYPES) ? NUM_TYPES - 1 : treg - 1;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < add_pct) begin
        f = FN_ADD;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 30) f = FN_REMOVE;
        else if (roll < 50) f = FN_GET;
        else if (roll < 75) f = FN_WRITE;
        else if (roll < 90) f = FN_DESTROY;
        else f = FUNC_W'($urandom_range(FN_DESTROY + 1, FN_MAX));
      end
      case ($urandom_range(0, 19))
        0: e = 0;
        1: e = $urandom_range(1, MAX_ENTITIES - 1);
        default: e = $urandom_range(1, pool);
      endcase
      if (hi_type < 0 || $urandom_range(0, 3) == 0) begin
        t = $urandom_range(0, NUM_TYPES - 1);
      end else begin
        t = $urandom_range(0, hi_type);
      end
      queue_op(f, e, t, $urandom);
      if ($urandom_range(0, 99) == 0) begin
        st.kind = K_DRAIN;
        st.treg = '0;
        st.word = '0;
        op_q.push_back(st);
      end
    end
  endtask

  // Driver: presents one word at a time and keeps the mirror in step with
  // every accepted word and register write.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      cfg_we <= 1'b0;
    end else begin
      go = start;
      we = 1'b0;
      if (start && !busy) begin
        outcome_q.push_back(run_table_op(item));
        go = 1'b0;
        if (burst_left > 0) begin
          burst_left--;
          hold_cnt = 0;
        end else if ($urandom_range(0, 15) == 0) begin
          burst_left = $urandom_range(10, 40);
          hold_cnt = 0;
        end else begin
          hold_cnt = $urandom_range(0, 11);
        end
      end
      if (!go) begin
        if (hold_cnt > 0) begin
          hold_cnt--;
        end else if (op_q.size() > 0) begin
          head = op_q[0];
          if (head.kind == K_OP) begin
            item <= head.word;
            go = 1'b1;
            void'(op_q.pop_front());
          end else if (outcome_q.size() == 0 && !result_valid) begin
            // Nothing outstanding: the block is idle.
            if (head.kind == K_CFG) begin
              cfg_data <= head.treg;
              we = 1'b1;
              treg_m = 32'(head.treg);
            end
            void'(op_q.pop_front());
          end
        end
      end
      start <= go;
      cfg_we <= we;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (outcome_q.size() == 0) begin
        bad_words++;
        if (bad_words <= MAX_REPORTS) begin
          $display("unexpected result word: status %0d slot %0d rdata %h present %0b",
                   result.status, result.slot, result.rdata, result.was_present);
        end
      end else begin
        exp_w = outcome_q.pop_front();
        if (result.status !== exp_w.status || result.slot !== exp_w.slot ||
            result.rdata !== exp_w.rdata || result.was_present !== exp_w.was_present) begin
          bad_words++;
          if (bad_words <= MAX_REPORTS) begin
            $display("result word mismatch: expected status %0d slot %0d rdata %h present %0b",
                     exp_w.status, exp_w.slot, exp_w.rdata, exp_w.was_present);
            $display("                      got      status %0d slot %0d rdata %h present %0b",
                     result.status, result.slot, result.rdata, result.was_present);
          end
        end
      end
    end
  end

  // The map clearing pass after reset keeps busy high while it clears every map
  // entry, which the limit allows for.
  always @(posedge clk) begin
    if (!rst) begin
      if ((start && !busy) || result_valid || cfg_we) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("[sparse_set_component_table] ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    for (int t = 0; t < NUM_TYPES; t++) begin
      live_m[t] = 0;
      for (int e = 0; e < MAX_ENTITIES; e++) begin
        map_m[t][e] = '0;
      end
    end
    treg_m = 0;

    // Before any register write no type is registered.
    queue_op(FN_ADD, 5, 0, 32'h1234_5678);
    queue_cfg(NUM_TYPES);
    queue_op(FN_ADD, 0, 0, '0);
    queue_op(FN_ADD, MAX_ENTITIES - 1, NUM_TYPES - 1, '1);
    queue_op(FN_ADD, 1, 0, '0);
    queue_op(FN_ADD, 1, 0, '0);
    queue_op(FN_WRITE, 1, 0, '1);
    queue_op(FN_GET, 1, 0, '0);
    queue_op(FN_ADD, 2, 0, '0);
    queue_op(FN_WRITE, 2, 0, 32'hA5A5_5A5A);
    queue_op(FN_REMOVE, 1, 0, '0);
    queue_op(FN_GET, 2, 0, '0);
    queue_op(FN_REMOVE, 1, 0, '0);
    queue_op(FN_GET, 7, 1, '0);
    queue_op(FN_WRITE, 7, 1, '1);
    queue_op(FUNC_W'(FN_DESTROY + 1), 0, 3, '1);
    queue_op(FUNC_W'(FN_MAX), MAX_ENTITIES - 1, 0, '0);
    queue_op(FN_ADD, 2, 1, '0);
    queue_op(FN_ADD, 2, 2, '0);
    queue_op(FN_DESTROY, 2, 3, '0);
    queue_op(FN_DESTROY, 2, 0, '0);
    queue_op(FN_DESTROY, 0, 0, '0);
    queue_op(FN_ADD, 3, 0, '0);
    queue_op(FN_WRITE, 3, 0, '0);
    queue_op(FN_REMOVE, 3, 0, '0);

    queue_phase(4, 300, 48, 40);
    // One type only, add-heavy: the table reaches its capacity.
    queue_phase(1, 200, 40, 65);
    queue_phase(0, 60, 40, 40);
    queue_phase(2, 250, 64, 35);
    queue_phase(7, 150, 48, 40);
    // Type 3 unregistered: its entries stay hidden until raised again.
    queue_phase(3, 200, 64, 35);
    queue_phase(5, 100, 48, 45);
    queue_phase(4, 200, 48, 30);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    while (op_q.size() > 0 || start || outcome_q.size() > 0) begin
      @(negedge clk);
    end
    repeat (40) @(posedge clk);
    bad_words += outcome_q.size();
    if (bad_words == 0) begin
      $display("[sparse_set_component_table] OK");
    end else begin
      $display("[sparse_set_component_table] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
